### hw/rtl/bpfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

    // Map geometry
    localparam int unsigned NUM_PAGES  = 65536;
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned BIT_W      = $clog2(WORD_BITS);
    localparam int unsigned MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_AW    = $clog2(MAP_WORDS);

    // Beat field widths
    localparam int unsigned REQ_W  = 2;
    localparam int unsigned ADDR_W = 28;
    localparam int unsigned PAGE_W = 16;
    localparam int unsigned END_W  = 17;
    localparam int unsigned STAT_W = 2;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC      = 2'd0,
        REQ_FREE       = 2'd1,
        REQ_RANGE_FREE = 2'd2,
        REQ_RANGE_USED = 2'd3
    } req_t;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NO_PAGE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Word unit control: bit span of the current word and the write polarity
    typedef struct packed {
        logic [BIT_W-1:0] lo;
        logic [BIT_W-1:0] hi;
        logic             set_bits;
    } word_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/bpfa_word_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module bpfa_word_unit
(
    input  wire logic [bpfa_pkg::WORD_BITS-1:0] word_data,
    input  wire bpfa_pkg::word_ctl_t            ctl,
    output logic [bpfa_pkg::WORD_BITS-1:0]      range_data,
    output logic [bpfa_pkg::WORD_BITS-1:0]      alloc_data,
    output logic                                any_free,
    output logic [bpfa_pkg::BIT_W-1:0]          low_bit
);

    localparam logic [bpfa_pkg::WORD_BITS-1:0] ONES = '1;
    localparam logic [bpfa_pkg::BIT_W-1:0]     TOP  = bpfa_pkg::BIT_W'(bpfa_pkg::WORD_BITS - 1);

    logic [bpfa_pkg::WORD_BITS-1:0] span_mask;

    // Span of bits lo..hi inside the word, then set or clear them
    always_comb
    begin
        span_mask  = (ONES << ctl.lo) & (ONES >> (TOP - ctl.hi));
        range_data = ctl.set_bits ? (word_data | span_mask) : (word_data & ~span_mask);
    end

    // Lowest free bit of the word
    always_comb
    begin
        low_bit = '0;
        for (int i = bpfa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (word_data[i])
            begin
                low_bit = bpfa_pkg::BIT_W'(i);
            end
        end
        any_free   = |word_data;
        alloc_data = word_data & ~({{(bpfa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << low_bit);
    end

endmodule

`default_nettype wire

### hw/rtl/bitmap_page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// After reset all 2048 map words are cleared one word a cycle, with tready low.
// Allocate: map words are scanned (a read and an evaluate state per word) from the lowest word
//   that may hold a free page; a full map answers without a scan.
// Free: one read-modify-write. Range: one read-modify-write per map word touched; rejected or empty, none.
// One request at a time; the map port (one read, one write a cycle) sets the pace.

module bitmap_page_frame_allocator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_type[1:0], byte_address[29:2], first_page[45:30], stop_page[62:46], zero[63]
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], page_address[29:2], zero[31:30]
    output logic [31:0]      m_axis_tdata
);

    localparam int unsigned WB  = bpfa_pkg::WORD_BITS;
    localparam int unsigned WA  = bpfa_pkg::WORD_AW;
    localparam int unsigned PW  = bpfa_pkg::PAGE_W;
    localparam int unsigned BW  = bpfa_pkg::BIT_W;
    localparam int unsigned AW  = bpfa_pkg::ADDR_W;
    localparam int unsigned EW  = bpfa_pkg::END_W;
    localparam logic [WA:0]   NO_FREE_WORD = (WA + 1)'(bpfa_pkg::MAP_WORDS);
    localparam logic [WA-1:0] LAST_WORD    = WA'(bpfa_pkg::MAP_WORDS - 1);
    localparam logic [EW-1:0] PAGES_END    = EW'(bpfa_pkg::NUM_PAGES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MODIFY,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [WA-1:0]           word_reg, word_next;
    logic [WA:0]             low_reg, low_next;
    logic [PW-1:0]           first_reg, first_next;
    logic [PW-1:0]           last_reg, last_next;
    logic                    set_reg, set_next;
    logic                    alloc_reg, alloc_next;
    bpfa_pkg::status_t       status_reg, status_next;
    logic [AW-1:0]           res_addr_reg, res_addr_next;
    logic                    m_valid_reg, m_valid_next;
    bpfa_pkg::status_t       out_status_reg, out_status_next;
    logic [AW-1:0]           out_addr_reg, out_addr_next;

    // Map memory
    logic [WB-1:0]           map_mem [bpfa_pkg::MAP_WORDS];
    logic [WB-1:0]           rdata_reg;
    logic                    mem_we;
    logic [WB-1:0]           mem_wdata;

    // Word unit
    bpfa_pkg::word_ctl_t     ctl;
    logic [WB-1:0]           range_data;
    logic [WB-1:0]           alloc_data;
    logic                    any_free;
    logic [BW-1:0]           low_bit;

    // Input beat fields
    logic [bpfa_pkg::REQ_W-1:0] in_req;
    logic [AW-1:0]           in_addr;
    logic [PW-1:0]           in_first;
    logic [EW-1:0]           in_end;
    logic [PW-1:0]           in_page;
    logic [EW-1:0]           in_end_m1;
    logic                    in_accept;

    assign in_req    = s_axis_tdata[1:0];
    assign in_addr   = s_axis_tdata[29:2];
    assign in_first  = s_axis_tdata[45:30];
    assign in_end    = s_axis_tdata[62:46];
    assign in_page   = in_addr[AW-1:bpfa_pkg::PAGE_SHIFT];
    assign in_end_m1 = in_end - EW'(1);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, out_addr_reg, out_status_reg};

    // Bit span of the current word
    always_comb
    begin
        ctl.lo       = (word_reg == first_reg[PW-1:BW]) ? first_reg[BW-1:0] : '0;
        ctl.hi       = (word_reg == last_reg[PW-1:BW]) ? last_reg[BW-1:0] : '1;
        ctl.set_bits = set_reg;
    end

    bpfa_word_unit u_word_unit
    (
        .word_data  (rdata_reg),
        .ctl        (ctl),
        .range_data (range_data),
        .alloc_data (alloc_data),
        .any_free   (any_free),
        .low_bit    (low_bit)
    );

    // Map memory: one write, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[word_reg] <= mem_wdata;
        end
        rdata_reg <= map_mem[word_reg];
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        low_next        = low_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        set_next        = set_reg;
        alloc_next      = alloc_reg;
        status_next     = status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WA'(1);
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    status_next   = bpfa_pkg::ST_DONE;
                    res_addr_next = '0;
                    alloc_next    = (in_req == bpfa_pkg::REQ_ALLOC);
                    state_next    = S_DONE;
                    case (in_req)
                        bpfa_pkg::REQ_ALLOC:
                        begin
                            if (low_reg == NO_FREE_WORD)
                            begin
                                status_next = bpfa_pkg::ST_NO_PAGE;
                            end
                            else
                            begin
                                word_next  = low_reg[WA-1:0];
                                state_next = S_READ;
                            end
                        end
                        bpfa_pkg::REQ_FREE:
                        begin
                            if ({1'b0, in_page} >= PAGES_END)
                            begin
                                status_next = bpfa_pkg::ST_RANGE;
                            end
                            else
                            begin
                                first_next = in_page;
                                last_next  = in_page;
                                set_next   = 1'b1;
                                word_next  = in_page[PW-1:BW];
                                if ({1'b0, in_page[PW-1:BW]} < low_reg)
                                begin
                                    low_next = {1'b0, in_page[PW-1:BW]};
                                end
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            if (in_end > PAGES_END)
                            begin
                                status_next = bpfa_pkg::ST_RANGE;
                            end
                            else if ({1'b0, in_first} < in_end)
                            begin
                                first_next = in_first;
                                last_next  = in_end_m1[PW-1:0];
                                set_next   = (in_req == bpfa_pkg::REQ_RANGE_FREE);
                                word_next  = in_first[PW-1:BW];
                                if ((in_req == bpfa_pkg::REQ_RANGE_FREE) &&
                                    ({1'b0, in_first[PW-1:BW]} < low_reg))
                                begin
                                    low_next = {1'b0, in_first[PW-1:BW]};
                                end
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = alloc_reg ? S_EVAL : S_MODIFY;
            end

            // Allocate scan: take the first word with a free bit
            S_EVAL:
            begin
                if (any_free)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = alloc_data;
                    res_addr_next = {word_reg, low_bit, {bpfa_pkg::PAGE_SHIFT{1'b0}}};
                    low_next      = {1'b0, word_reg};
                    state_next    = S_DONE;
                end
                else if (word_reg == LAST_WORD)
                begin
                    status_next = bpfa_pkg::ST_NO_PAGE;
                    low_next    = NO_FREE_WORD;
                    state_next  = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + WA'(1);
                    state_next = S_READ;
                end
            end

            // Range walk: read-modify-write one word
            S_MODIFY:
            begin
                mem_we    = 1'b1;
                mem_wdata = range_data;
                if (word_reg == last_reg[PW-1:BW])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    word_next  = word_reg + WA'(1);
                    state_next = S_READ;
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            word_reg       <= '0;
            low_reg        <= NO_FREE_WORD;
            first_reg      <= '0;
            last_reg       <= '0;
            set_reg        <= 1'b0;
            alloc_reg      <= 1'b0;
            status_reg     <= bpfa_pkg::ST_DONE;
            res_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            out_status_reg <= bpfa_pkg::ST_DONE;
            out_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            low_reg        <= low_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            set_reg        <= set_next;
            alloc_reg      <= alloc_next;
            status_reg     <= status_next;
            res_addr_reg   <= res_addr_next;
            m_valid_reg    <= m_valid_next;
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
    end

`ifndef SYNTH
    // Scan start never points past the map
    a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg <= NO_FREE_WORD)
        else $error("scan start beyond map");

    // An allocate on a full map answers without touching the memory
    a_full_map: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_req == bpfa_pkg::REQ_ALLOC) && (low_reg == NO_FREE_WORD))
        |=> (state_reg == S_DONE) && (status_reg == bpfa_pkg::ST_NO_PAGE))
        else $error("full map allocate not short-cut");

    // A result with an error status carries a zero address
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_status_reg != bpfa_pkg::ST_DONE)) |-> (out_addr_reg == '0))
        else $error("nonzero address on error status");

    // Map writes happen only in clearing, scan or range states
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == S_CLEAR) || (state_reg == S_EVAL) ||
                    (state_reg == S_MODIFY)))
        else $error("map write outside a write state");
`endif

endmodule

`default_nettype wire
